### rtl/mono_mix_linear_resampler_defines.svh
// assertion macros shared by the resampler
`ifndef MONO_MIX_LINEAR_RESAMPLER_DEFINES_SVH
`define MONO_MIX_LINEAR_RESAMPLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MMLR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmlr same-cycle check failed");

// next-cycle implication, checked outside reset
`define MMLR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmlr next-cycle check failed");

`endif

### rtl/mmlr_pkg.sv
package mmlr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CC_W        = 4;
  localparam int RATE_W      = 18;
  localparam int RATE_MIN    = 8000;
  localparam int RATE_MAX    = 192000;
  localparam int MAX_RESULTS = 4;
  localparam int NC_W        = 3;
  localparam int REG_IDX_W   = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_SOURCE_RATE   = 1'b1
  } mmlr_reg_t;

  typedef struct packed {
    logic take;
    logic div_mul;
    logic div_fin;
    logic mul1;
    logic mul2;
    logic mul3;
    logic emit_interp;
    logic emit_copy;
    logic emit_pass;
    logic adjust;
    logic finish;
  } mmlr_cmd_t;

  typedef struct packed {
    logic close_frame;
    logic pass_mode;
    logic have_prev;
    logic last_frame;
    logic loop_go;
    logic out_free;
  } mmlr_status_t;

endpackage

### rtl/mmlr_in_if.sv
interface mmlr_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic                           end_of_buffer_in;

  modport source (output valid, output in_sample, output end_of_buffer_in, input ready);
  modport sink (input valid, input in_sample, input end_of_buffer_in, output ready);
endinterface

### rtl/mmlr_out_if.sv
interface mmlr_out_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           last_of_run;
  logic                           end_of_buffer_out;

  modport source (
    output valid, output out_sample, output last_of_run, output end_of_buffer_out,
    input ready
  );
  modport sink (
    input valid, input out_sample, input last_of_run, input end_of_buffer_out,
    output ready
  );
endinterface

### rtl/mmlr_ctrl.sv
module mmlr_ctrl
  import mmlr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  mmlr_status_t status,
  output mmlr_cmd_t    cmd
);

  typedef enum logic [13:0] {
    IDLE     = 14'h0001,
    DIV_MUL  = 14'h0002,
    DIV_FIN  = 14'h0004,
    DISPATCH = 14'h0008,
    I_CHECK  = 14'h0010,
    I_MUL1   = 14'h0020,
    I_MUL2   = 14'h0040,
    I_MUL3   = 14'h0080,
    I_EMIT   = 14'h0100,
    ADJUST   = 14'h0200,
    C_CHECK  = 14'h0400,
    C_EMIT   = 14'h0800,
    P_EMIT   = 14'h1000,
    FINISH   = 14'h2000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        cmd.take = item_valid;
        if (item_valid && status.close_frame) begin
          state_next = DIV_MUL;
        end
      end
      DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_next  = DIV_FIN;
      end
      DIV_FIN: begin
        cmd.div_fin = 1'b1;
        state_next  = DISPATCH;
      end
      DISPATCH: begin
        if (status.pass_mode) begin
          state_next = P_EMIT;
        end else if (status.have_prev) begin
          state_next = I_CHECK;
        end else if (status.last_frame) begin
          state_next = C_CHECK;
        end else begin
          state_next = FINISH;
        end
      end
      I_CHECK: begin
        state_next = status.loop_go ? I_MUL1 : ADJUST;
      end
      I_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = I_MUL2;
      end
      I_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = I_MUL3;
      end
      I_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = I_EMIT;
      end
      I_EMIT: begin
        if (status.out_free) begin
          cmd.emit_interp = 1'b1;
          state_next      = I_CHECK;
        end
      end
      ADJUST: begin
        cmd.adjust = 1'b1;
        state_next = status.last_frame ? C_CHECK : FINISH;
      end
      C_CHECK: begin
        state_next = status.loop_go ? C_EMIT : FINISH;
      end
      C_EMIT: begin
        if (status.out_free) begin
          cmd.emit_copy = 1'b1;
          state_next    = C_CHECK;
        end
      end
      P_EMIT: begin
        if (status.out_free) begin
          cmd.emit_pass = 1'b1;
          state_next    = FINISH;
        end
      end
      FINISH: begin
        cmd.finish = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

### rtl/mmlr_dp.sv
module mmlr_dp
  import mmlr_pkg::*;
#(
  parameter int TARGET_RATE  = 16000,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [REG_IDX_W-1:0]           cfg_index,
  input  logic [RATE_W-1:0]              cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           end_of_buffer_in,
  input  mmlr_cmd_t                      cmd,
  output mmlr_status_t                   status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample,
  output logic                           last_of_run,
  output logic                           end_of_buffer_out
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int CI_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W   = SW + $clog2(MAX_CHANNELS);
  localparam int NUM_W   = SUM_W + 1;
  localparam int K       = NUM_W + 3;
  localparam int M_W     = K + 1;
  localparam int TW      = $clog2(TARGET_RATE + 1);
  localparam int PH_W    = $clog2(RATE_MAX + TARGET_RATE);
  localparam int NW      = FRAC_BITS + TW;
  localparam longint unsigned MREC = (64'd1 << NW) / TARGET_RATE;
  localparam int M_RW    = FRAC_BITS + 2;
  localparam int P1_W    = NW + M_RW;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int P2_W    = Q_W + TW;
  localparam int D_W     = SW + 1;
  localparam int P3_W    = D_W + Q_W + 1;
  localparam int RATE_LO = (RATE_MIN > (TARGET_RATE + 1) / 2) ? RATE_MIN
                                                                : (TARGET_RATE + 1) / 2;

  function automatic logic [M_W-1:0] recip(input logic [CC_W-1:0] c);
    logic [M_W-1:0] r;
    case (c)
      4'd2:    r = M_W'(((64'd1 << K) + 64'd1) / 2);
      4'd3:    r = M_W'(((64'd1 << K) + 64'd2) / 3);
      4'd4:    r = M_W'(((64'd1 << K) + 64'd3) / 4);
      4'd5:    r = M_W'(((64'd1 << K) + 64'd4) / 5);
      4'd6:    r = M_W'(((64'd1 << K) + 64'd5) / 6);
      4'd7:    r = M_W'(((64'd1 << K) + 64'd6) / 7);
      4'd8:    r = M_W'(((64'd1 << K) + 64'd7) / 8);
      default: r = M_W'(64'd1 << K);
    endcase
    return r;
  endfunction

  logic [CC_W-1:0]          channel_count;
  logic [RATE_W-1:0]        source_rate;
  logic [CI_W-1:0]          channel_index;
  logic signed [SUM_W-1:0]  mix_sum;
  logic signed [SUM_W-1:0]  frame_sum;
  logic                     last_frame;
  logic signed [SW-1:0]     previous_mono;
  logic signed [SW-1:0]     cur;
  logic                     have_previous;
  logic [PH_W-1:0]          phase;
  logic [PH_W-1:0]          p;
  logic [NC_W-1:0]          n;
  logic [NUM_W+M_W-1:0]     div_prod;
  logic [NW-1:0]            n_reg;
  logic [P1_W-1:0]          prod1;
  logic [Q_W-1:0]           q0;
  logic [P2_W-1:0]          prod2;
  logic signed [P3_W-1:0]   prod3;

  logic [CC_W-1:0]          eff_c;
  logic [RATE_W-1:0]        eff_rate;
  logic signed [SUM_W-1:0]  total;
  logic [SUM_W-1:0]         mag;
  logic [NUM_W-1:0]         num;
  logic [SW-1:0]            qv;
  logic [NW-1:0]            nval;
  logic [NW-1:0]            rem;
  logic [Q_W-1:0]           frac;
  logic signed [D_W-1:0]    diff;
  logic signed [P3_W-1:0]   v;
  logic [PH_W-1:0]          p1;
  logic                     n_more;
  logic                     more_i;
  logic                     more_c;
  logic                     out_free;

  always_comb begin
    if (channel_count == '0) begin
      eff_c = CC_W'(1);
    end else if (channel_count > CC_W'(MAX_CHANNELS)) begin
      eff_c = CC_W'(MAX_CHANNELS);
    end else begin
      eff_c = channel_count;
    end
    if (source_rate < RATE_W'(RATE_LO)) begin
      eff_rate = RATE_W'(RATE_LO);
    end else if (source_rate > RATE_W'(RATE_MAX)) begin
      eff_rate = RATE_W'(RATE_MAX);
    end else begin
      eff_rate = source_rate;
    end
  end

  assign total = mix_sum + SUM_W'(in_sample);
  assign mag   = frame_sum[SUM_W-1] ? SUM_W'(-frame_sum) : SUM_W'(frame_sum);
  assign num   = NUM_W'(mag) + NUM_W'(eff_c >> 1);
  assign qv    = div_prod[K +: SW];

  assign nval  = {p[TW-1:0], {FRAC_BITS{1'b0}}} + NW'(TARGET_RATE / 2);
  assign rem   = n_reg - prod2[NW-1:0];
  assign frac  = (rem >= NW'(TARGET_RATE)) ? q0 + Q_W'(1) : q0;
  assign diff  = D_W'(cur) - D_W'(previous_mono);
  assign v     = (P3_W'(previous_mono) <<< FRAC_BITS) + prod3
               + P3_W'(1 << (FRAC_BITS - 1));

  assign p1     = p + PH_W'(eff_rate);
  assign n_more = (n < NC_W'(MAX_RESULTS - 1));
  assign more_c = n_more && (p1 < PH_W'(TARGET_RATE));
  assign more_i = n_more && ((p1 < PH_W'(TARGET_RATE)) ||
                  (last_frame && ((p1 - PH_W'(TARGET_RATE)) < PH_W'(TARGET_RATE))));

  assign out_free = !out_valid || out_ready;

  always_comb begin
    status.close_frame = (CC_W'(channel_index) + CC_W'(1) >= eff_c) || end_of_buffer_in;
    status.pass_mode   = (eff_rate == RATE_W'(TARGET_RATE));
    status.have_prev   = have_previous;
    status.last_frame  = last_frame;
    status.loop_go     = (p < PH_W'(TARGET_RATE)) && (n < NC_W'(MAX_RESULTS));
    status.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CC_W'(1);
      source_rate   <= RATE_W'(16000);
    end else if (cfg_we) begin
      unique case (mmlr_reg_t'(cfg_index))
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CC_W-1:0];
        REG_SOURCE_RATE:   source_rate   <= cfg_data;
      endcase
    end
  end

  // frame accumulation, history and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      mix_sum       <= '0;
      previous_mono <= '0;
      have_previous <= 1'b0;
      phase         <= '0;
    end else begin
      if (cmd.take) begin
        if (status.close_frame) begin
          mix_sum       <= '0;
          channel_index <= '0;
        end else begin
          mix_sum       <= total;
          channel_index <= channel_index + CI_W'(1);
        end
      end
      if (cmd.finish) begin
        phase         <= (last_frame || status.pass_mode) ? '0 : p;
        have_previous <= !last_frame;
        previous_mono <= last_frame ? '0 : cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.close_frame) begin
      frame_sum  <= total;
      last_frame <= end_of_buffer_in;
    end
    if (cmd.div_mul) begin
      div_prod <= num * recip(eff_c);
    end
    if (cmd.div_fin) begin
      cur <= frame_sum[SUM_W-1] ? -$signed(qv) : $signed(qv);
      p   <= phase;
      n   <= '0;
    end
    if (cmd.mul1) begin
      n_reg <= nval;
      prod1 <= nval * M_RW'(MREC);
    end
    if (cmd.mul2) begin
      q0    <= prod1[NW +: Q_W];
      prod2 <= prod1[NW +: Q_W] * TW'(TARGET_RATE);
    end
    if (cmd.mul3) begin
      prod3 <= diff * $signed({1'b0, frac});
    end
    if (cmd.emit_interp || cmd.emit_copy) begin
      p <= p1;
      n <= n + NC_W'(1);
    end
    if (cmd.adjust) begin
      p <= (p >= PH_W'(TARGET_RATE)) ? p - PH_W'(TARGET_RATE) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_interp || cmd.emit_copy || cmd.emit_pass) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_interp) begin
      out_sample        <= $signed(v[FRAC_BITS +: SW]);
      last_of_run       <= !more_i;
      end_of_buffer_out <= last_frame && !more_i;
    end else if (cmd.emit_copy) begin
      out_sample        <= cur;
      last_of_run       <= !more_c;
      end_of_buffer_out <= !more_c;
    end else if (cmd.emit_pass) begin
      out_sample        <= cur;
      last_of_run       <= 1'b1;
      end_of_buffer_out <= last_frame;
    end
  end

endmodule

### rtl/mono_mix_linear_resampler.sv
// Mono mix and linear-interpolation resampler to a fixed target rate.
// audio: one interleaved channel sample per transaction, with an end mark on
//   the last sample of a buffer. resampled: mono samples at TARGET_RATE, with
//   last_of_run on the last one caused by a transaction and end_of_buffer_out
//   on the last one of the buffer. Both are valid/ready channels.
// cfg_we/cfg_index/cfg_data write channel_count (index 0) and source_rate
//   (index 1); the user writes only while the block is idle (unenforced).
// Samples that do not close a frame are summed as they arrive, and ready
//   stays high. A closing sample starts a sequence: DIV_MUL and DIV_FIN
//   average the frame through a reciprocal multiply and DISPATCH picks a
//   path. Each interpolated output takes a check, three registered
//   multiplies and a load of the output register; each copied output a
//   check and a load; a passed one a load alone. A check state leaves
//   each loop, ADJUST wraps the phase after interpolation and FINISH
//   updates the history. Ready stays low until the sequence ends.
// The output register accepts no new result while it holds one that is not
//   taken, so a stalled receiver holds the sequence and lengthens it.
// Reset (rst, synchronous) clears the frame history and phase, empties the
//   output register and sets channel_count to 1 and source_rate to 16000.
`include "mono_mix_linear_resampler_defines.svh"

module mono_mix_linear_resampler
  import mmlr_pkg::*;
#(
  parameter int TARGET_RATE  = 16000,
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  mmlr_in_if.sink              audio,
  mmlr_out_if.source           resampled,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  mmlr_cmd_t    ctrl_cmd;
  mmlr_status_t dp_status;
  logic         in_close;
  logic         emit_any;

  mmlr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (audio.valid),
    .item_ready (audio.ready),
    .status     (dp_status),
    .cmd        (ctrl_cmd)
  );

  mmlr_dp #(
    .TARGET_RATE  (TARGET_RATE),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample         (audio.in_sample),
    .end_of_buffer_in  (audio.end_of_buffer_in),
    .cmd               (ctrl_cmd),
    .status            (dp_status),
    .out_ready         (resampled.ready),
    .out_valid         (resampled.valid),
    .out_sample        (resampled.out_sample),
    .last_of_run       (resampled.last_of_run),
    .end_of_buffer_out (resampled.end_of_buffer_out)
  );

  assign in_close = audio.valid && audio.ready && dp_status.close_frame;
  assign emit_any = ctrl_cmd.emit_interp || ctrl_cmd.emit_copy || ctrl_cmd.emit_pass;

  `MMLR_ASSERT_NEXT(a_busy_after_close, in_close, !audio.ready)
  `MMLR_ASSERT_IMP(a_emit_has_room, emit_any, dp_status.out_free)
  `MMLR_ASSERT_IMP(a_eob_ends_run, resampled.valid && resampled.end_of_buffer_out, resampled.last_of_run)

endmodule
